>>> hdl/pam_pkg.sv
package pam_pkg;

    localparam int TERMS       = 16;
    localparam int KIND_W      = 3;
    localparam int POWER_W     = 4;
    localparam int COEFF_W     = 16;
    localparam int OUT_POWER_W = 5;
    localparam int OUT_COEFF_W = 36;
    localparam int PROD_W      = 2 * COEFF_W;

    // Partial sums grow by log2(TERMS) bits over the product width; never narrower than the port.
    localparam int ACC_W = (PROD_W + $clog2(TERMS) > OUT_COEFF_W) ?
                           (PROD_W + $clog2(TERMS)) : OUT_COEFF_W;

    // Step counter covers 0 .. 2*TERMS-2.
    localparam int CNT_W = $clog2(2 * TERMS - 1);

    localparam logic signed [ACC_W-1:0] SAT_HI =
        {{(ACC_W - OUT_COEFF_W + 1){1'b0}}, {(OUT_COEFF_W - 1){1'b1}}};
    localparam logic signed [ACC_W-1:0] SAT_LO =
        {{(ACC_W - OUT_COEFF_W + 1){1'b1}}, {(OUT_COEFF_W - 1){1'b0}}};

    typedef enum logic [KIND_W-1:0] {
        KIND_CLEAR_A = 3'd0,
        KIND_CLEAR_B = 3'd1,
        KIND_WRITE_A = 3'd2,
        KIND_WRITE_B = 3'd3,
        KIND_ADD     = 3'd4,
        KIND_MUL     = 3'd5
    } kind_t;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_CLR_SUM,
        CELL_MAC,
        CELL_ADD
    } cell_op_t;

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } state_t;

    // Broadcast controls shared by every cell of the chain.
    typedef struct packed {
        cell_op_t                   op;
        logic                       clr_a;
        logic                       clr_b;
        logic                       rot_a;
        logic                       rot_b;
        logic signed [COEFF_W-1:0]  x;
        logic signed [COEFF_W-1:0]  wdata;
    } cell_ctl_t;

    function automatic logic signed [OUT_COEFF_W-1:0] sat_coeff(
        input logic signed [ACC_W-1:0] v
    );
        logic signed [OUT_COEFF_W-1:0] r;
        if (v > SAT_HI)
        begin
            r = SAT_HI[OUT_COEFF_W-1:0];
        end
        else if (v < SAT_LO)
        begin
            r = SAT_LO[OUT_COEFF_W-1:0];
        end
        else
        begin
            r = v[OUT_COEFF_W-1:0];
        end
        return r;
    endfunction

endpackage

>>> hdl/pam_cell.sv
module pam_cell (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  pam_pkg::cell_ctl_t                       ctl,
    input  logic                                     wr_a,
    input  logic                                     wr_b,
    input  logic signed [pam_pkg::COEFF_W-1:0]       a_in,
    input  logic signed [pam_pkg::COEFF_W-1:0]       b_in,
    input  logic signed [pam_pkg::ACC_W-1:0]         psum_in,
    output logic signed [pam_pkg::COEFF_W-1:0]       a_out,
    output logic signed [pam_pkg::COEFF_W-1:0]       b_out,
    output logic signed [pam_pkg::ACC_W-1:0]         psum_out
);

    logic signed [pam_pkg::COEFF_W-1:0] a_reg, a_next;
    logic signed [pam_pkg::COEFF_W-1:0] b_reg, b_next;
    logic signed [pam_pkg::ACC_W-1:0]   psum_reg, psum_next;
    logic signed [pam_pkg::PROD_W-1:0]  prod;

    assign prod = a_reg * ctl.x;

    always_comb
    begin
        a_next = a_reg;
        if (ctl.clr_a)
        begin
            a_next = '0;
        end
        else if (wr_a)
        begin
            a_next = ctl.wdata;
        end
        else if (ctl.rot_a)
        begin
            a_next = a_in;
        end

        b_next = b_reg;
        if (ctl.clr_b)
        begin
            b_next = '0;
        end
        else if (wr_b)
        begin
            b_next = ctl.wdata;
        end
        else if (ctl.rot_b)
        begin
            b_next = b_in;
        end

        case (ctl.op)
            pam_pkg::CELL_CLR_SUM: psum_next = '0;
            pam_pkg::CELL_MAC:     psum_next = psum_in + pam_pkg::ACC_W'(prod);
            pam_pkg::CELL_ADD:     psum_next = pam_pkg::ACC_W'(a_reg) + pam_pkg::ACC_W'(b_reg);
            default:               psum_next = psum_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_reg    <= '0;
            b_reg    <= '0;
            psum_reg <= '0;
        end
        else
        begin
            a_reg    <= a_next;
            b_reg    <= b_next;
            psum_reg <= psum_next;
        end
    end

    assign a_out    = a_reg;
    assign b_out    = b_reg;
    assign psum_out = psum_reg;

endmodule

>>> hdl/polynomial_add_multiply.sv
// A clear or write transfer is applied to the stored terms as it is taken; busy stays low.
// Add: the start is registered into the sequencer, then each step's result is registered in
// cell 0's sum register with the strobe; results come one per cycle, TERMS in all, and the
// next start is taken in the cycle of the last result. Multiply: 2*TERMS-1 results the same
// way, as the transposed multiply-accumulate chain drains one power per cycle. No output stall.
// Reset (rst_n low, async): both polynomials zero, sequencer idle, no strobe.
module polynomial_add_multiply (
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  logic                                        start,
    output logic                                        busy,
    input  logic [pam_pkg::KIND_W-1:0]                  kind,
    input  logic [pam_pkg::POWER_W-1:0]                 power,
    input  logic signed [pam_pkg::COEFF_W-1:0]          coeff,
    output logic                                        strobe,
    output logic [pam_pkg::OUT_POWER_W-1:0]             out_power,
    output logic signed [pam_pkg::OUT_COEFF_W-1:0]      out_coeff,
    output logic                                        last
);

    // Chain layout: cell i holds a[i] and b[i]. Partial sums flow toward cell 0
    // (transposed FIR form), so cell 0's sum register is the current result.
    // During a multiply b rotates toward cell 0 and cell 0's b is broadcast as x
    // for the first TERMS steps, then x is zero while the chain drains. After
    // TERMS rotations the coefficients are back in place. An add rotates both
    // a and b and cell 0 forms a[t] + b[t].

    pam_pkg::state_t    state_reg, state_next;
    logic               mul_reg, mul_next;        // 1: multiply run, 0: add run
    logic [pam_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic               valid_reg, valid_next;
    logic [pam_pkg::OUT_POWER_W-1:0] power_reg, power_next;
    logic               last_reg, last_next;

    pam_pkg::cell_ctl_t ctl;
    logic [pam_pkg::TERMS-1:0] wr_a;
    logic [pam_pkg::TERMS-1:0] wr_b;

    logic signed [pam_pkg::COEFF_W-1:0] a_link [pam_pkg::TERMS];
    logic signed [pam_pkg::COEFF_W-1:0] b_link [pam_pkg::TERMS];
    logic signed [pam_pkg::ACC_W-1:0]   psum_link [pam_pkg::TERMS+1];

    logic accept;
    logic feeding;      // multiply step still broadcasting stored b terms
    logic [pam_pkg::CNT_W-1:0] end_cnt;

    assign accept  = start && (state_reg == pam_pkg::ST_IDLE);
    assign feeding = cnt_reg < pam_pkg::CNT_W'(pam_pkg::TERMS);
    assign end_cnt = mul_reg ? pam_pkg::CNT_W'(2 * pam_pkg::TERMS - 2)
                             : pam_pkg::CNT_W'(pam_pkg::TERMS - 1);

    // Per-cell write enables for the addressed power.
    genvar g;
    generate
        for (g = 0; g < pam_pkg::TERMS; g++)
        begin : g_wr
            assign wr_a[g] = accept && (kind == pam_pkg::KIND_WRITE_A) && (int'(power) == g);
            assign wr_b[g] = accept && (kind == pam_pkg::KIND_WRITE_B) && (int'(power) == g);
        end
    endgenerate

    always_comb
    begin
        state_next = state_reg;
        mul_next   = mul_reg;
        cnt_next   = cnt_reg;
        valid_next = 1'b0;
        power_next = power_reg;
        last_next  = last_reg;

        ctl.op    = pam_pkg::CELL_HOLD;
        ctl.clr_a = 1'b0;
        ctl.clr_b = 1'b0;
        ctl.rot_a = 1'b0;
        ctl.rot_b = 1'b0;
        ctl.x     = '0;
        ctl.wdata = coeff;

        case (state_reg)
            pam_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    case (kind)
                        pam_pkg::KIND_CLEAR_A: ctl.clr_a = 1'b1;
                        pam_pkg::KIND_CLEAR_B: ctl.clr_b = 1'b1;
                        pam_pkg::KIND_ADD:
                        begin
                            state_next = pam_pkg::ST_RUN;
                            mul_next   = 1'b0;
                            cnt_next   = '0;
                        end
                        pam_pkg::KIND_MUL:
                        begin
                            state_next = pam_pkg::ST_RUN;
                            mul_next   = 1'b1;
                            cnt_next   = '0;
                            ctl.op     = pam_pkg::CELL_CLR_SUM;
                        end
                        default: ;   // writes handled by per-cell enables; unused kinds ignored
                    endcase
                end
            end
            pam_pkg::ST_RUN:
            begin
                valid_next = 1'b1;
                power_next = pam_pkg::OUT_POWER_W'(cnt_reg);
                last_next  = (cnt_reg == end_cnt);
                if (mul_reg)
                begin
                    ctl.op    = pam_pkg::CELL_MAC;
                    ctl.rot_b = feeding;
                    ctl.x     = feeding ? b_link[0] : '0;
                end
                else
                begin
                    ctl.op    = pam_pkg::CELL_ADD;
                    ctl.rot_a = 1'b1;
                    ctl.rot_b = 1'b1;
                end
                if (cnt_reg == end_cnt)
                begin
                    state_next = pam_pkg::ST_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            default: state_next = pam_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pam_pkg::ST_IDLE;
            mul_reg   <= 1'b0;
            cnt_reg   <= '0;
            valid_reg <= 1'b0;
            last_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            mul_reg   <= mul_next;
            cnt_reg   <= cnt_next;
            valid_reg <= valid_next;
            last_reg  <= last_next;
        end
    end

    // Result power needs no reset; it is only looked at under strobe.
    always_ff @(posedge clk)
    begin
        power_reg <= power_next;
    end

    assign psum_link[pam_pkg::TERMS] = '0;

    generate
        for (g = 0; g < pam_pkg::TERMS; g++)
        begin : g_cell
            pam_cell u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .ctl      (ctl),
                .wr_a     (wr_a[g]),
                .wr_b     (wr_b[g]),
                .a_in     (a_link[(g + 1) % pam_pkg::TERMS]),
                .b_in     (b_link[(g + 1) % pam_pkg::TERMS]),
                .psum_in  (psum_link[g + 1]),
                .a_out    (a_link[g]),
                .b_out    (b_link[g]),
                .psum_out (psum_link[g])
            );
        end
    endgenerate

    assign busy      = (state_reg == pam_pkg::ST_RUN);
    assign strobe    = valid_reg;
    assign out_power = power_reg;
    assign out_coeff = pam_pkg::sat_coeff(psum_link[0]);
    assign last      = last_reg;

endmodule
